/* src/ebtd_pkg.sv */
package ebtd_pkg;

    // Field widths of the channels.
    localparam int SAMPLE_W    = 48;
    localparam int STATUS_W    = 3;
    localparam int TS_W        = 32;
    localparam int BIT_LEN_W   = 16;
    localparam int FRAME_LEN_W = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // A run that is accepted never exceeds frame length plus tolerance.
    localparam int RUN_W  = FRAME_LEN_W + 1;
    // Rounding divide: (2 * run + b) / (2 * b).
    localparam int NUM_W  = RUN_W + 2;
    localparam int DEN_W  = BIT_LEN_W + 1;
    // Difference of two sample numbers, with sign.
    localparam int DIFF_W = SAMPLE_W + 1;

    // Register values after reset.
    localparam logic [BIT_LEN_W-1:0]   BIT_LEN_RESET   = 16'd30;
    localparam logic [BIT_LEN_W-1:0]   BIT_TOL_RESET   = 16'd6;
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 24'd1170;
    localparam logic [FRAME_LEN_W-1:0] FRAME_TOL_RESET = 24'd150;
    localparam logic [FRAME_LEN_W-1:0] GAP_RESET       = 24'd15000;

    // Frame layout: four LSB-first bytes and three stop/start pairs.
    localparam int BYTES  = 4;
    localparam int BYTE_W = 8;
    localparam int unsigned BYTE_START [BYTES] = '{1, 11, 21, 31};
    localparam int PAIRS  = 3;
    localparam int unsigned PAIR_FIRST [PAIRS] = '{9, 19, 29};

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_RUN    = 3'd1,
        ST_FEW_BITS   = 3'd2,
        ST_BAD_STRUCT = 3'd3,
        ST_BAD_FRAME  = 3'd4,
        ST_BAD_TIMING = 3'd5
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BIT_LEN   = 3'd0,
        CFG_BIT_TOL   = 3'd1,
        CFG_FRAME_LEN = 3'd2,
        CFG_FRAME_TOL = 3'd3,
        CFG_GAP       = 3'd4
    } t_cfg_index;

    // Channel payloads.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_number;
        logic                level;
    } t_edge;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TS_W-1:0]     timestamp;
        logic [SAMPLE_W-1:0] frame_start_sample;
    } t_result;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } t_cfg_write;

    // Request to the serial divider.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    // Control of the frame shift register.
    typedef struct packed {
        logic shift;
        logic bit_in;
    } t_fill_ctl;

    // What the frame shift register reports about a full frame.
    typedef struct packed {
        logic            structure_ok;
        logic [TS_W-1:0] timestamp;
    } t_frame_view;

endpackage

/* src/ebtd_stream_if.sv */
interface ebtd_stream_if #(
    parameter type t_payload = logic
);

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

/* src/ebtd_divider.sv */
module ebtd_divider import ebtd_pkg::*; #(
    parameter int Q_W = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_div_req       i_req,
    output logic           o_done,
    output logic [Q_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quot;
    logic             r_sat;

    logic [DEN_W:0]   partial;
    logic [DEN_W+1:0] trial;
    logic             q_bit;
    logic [DEN_W-1:0] n_rem;

    // One restoring step: bring down the next numerator bit and try the divisor.
    always_comb begin
        partial = {r_rem, r_num[NUM_W-1]};
        trial   = {1'b0, partial} - {2'b00, r_den};
        q_bit   = ~trial[DEN_W+1];
        n_rem   = q_bit ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
    end

    // Iterate one quotient bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quot <= '0;
                r_sat  <= 1'b0;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_rem  <= n_rem;
                r_quot <= {r_quot[Q_W-2:0], q_bit};
                r_sat  <= r_sat | r_quot[Q_W-1];
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The quotient saturates; the caller clamps it to the open bit count anyway.
    assign o_done     = r_done;
    assign o_quotient = r_sat ? '1 : r_quot;

endmodule

/* src/ebtd_serial_mul.sv */
module ebtd_serial_mul import ebtd_pkg::*; #(
    parameter int N_W = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [N_W-1:0]           i_n,
    input  logic [BIT_LEN_W-1:0]     i_a,
    input  logic [BIT_LEN_W-1:0]     i_b,
    output logic                     o_done,
    output logic [BIT_LEN_W+N_W-1:0] o_prod_a,
    output logic [BIT_LEN_W+N_W-1:0] o_prod_b
);

    localparam int PROD_W = BIT_LEN_W + N_W;
    localparam int CNT_W  = $clog2(N_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [N_W-1:0]    r_n;
    logic [PROD_W-1:0] r_ma;
    logic [PROD_W-1:0] r_mb;
    logic [PROD_W-1:0] r_acc_a;
    logic [PROD_W-1:0] r_acc_b;

    // Shift-and-add, one multiplier bit per cycle, both products together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt   <= CNT_W'(N_W);
                r_n     <= i_n;
                r_ma    <= PROD_W'(i_a);
                r_mb    <= PROD_W'(i_b);
                r_acc_a <= '0;
                r_acc_b <= '0;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                r_n   <= r_n >> 1;
                r_ma  <= r_ma << 1;
                r_mb  <= r_mb << 1;
                if (r_n[0]) begin
                    r_acc_a <= r_acc_a + r_ma;
                    r_acc_b <= r_acc_b + r_mb;
                end
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_prod_a = r_acc_a;
    assign o_prod_b = r_acc_b;

endmodule

/* src/ebtd_frame_shift.sv */
module ebtd_frame_shift import ebtd_pkg::*; #(
    parameter int FRAME_BITS = 40
) (
    input  logic        i_clk,
    input  t_fill_ctl   i_ctl,
    output t_frame_view o_view
);

    logic [FRAME_BITS-1:0] r_bits;

    // Bits enter at the top; after a full frame, frame bit k sits at index k.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_bits <= {i_ctl.bit_in, r_bits[FRAME_BITS-1:1]};
        end
    end

    // Start bit low, each stop/start pair different, and the four data bytes.
    always_comb begin
        o_view.structure_ok = ~r_bits[0];
        for (int p = 0; p < PAIRS; p++) begin
            if (r_bits[PAIR_FIRST[p]] == r_bits[PAIR_FIRST[p] + 1]) begin
                o_view.structure_ok = 1'b0;
            end
        end
        for (int k = 0; k < BYTES; k++) begin
            for (int j = 0; j < BYTE_W; j++) begin
                o_view.timestamp[k * BYTE_W + j] = r_bits[BYTE_START[k] + j];
            end
        end
    end

endmodule

/* src/edge_barcode_timestamp_decoder.sv */
// Channel   Direction  Beat contents                                  Handshake
// i_edge    in         sample_number[47:0], level                     valid / ready
// o_result  out        status[2:0], timestamp[31:0],                  valid / ready
//                      frame_start_sample[47:0]
// i_cfg     in         index[2:0], data[23:0]                         valid / ready
//
// One edge is worked on at a time. An edge that opens a frame, is ignored or is
// a bad run passes the difference, classify and finish states. A run that becomes
// bits passes the 27-step bit-serial rounding divider, the serial multiplier with
// one step per bit of the count, the timing check, and the frame register, which
// takes one bit per cycle. A frame close passes the span, deviation and emit
// states, waiting in emit for the output register to empty. Reset is synchronous,
// active low, and drops an open frame. The result register lets o_result stall
// without holding back edges, until the next closed frame needs it.
module edge_barcode_timestamp_decoder import ebtd_pkg::*; #(
    parameter int FRAME_BITS = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ebtd_stream_if.sink          i_edge,
    ebtd_stream_if.source        o_result,
    ebtd_stream_if.sink          i_cfg
);

    localparam int CNT_W  = $clog2(FRAME_BITS + 1);
    localparam int Q_W    = CNT_W + 1;
    localparam int PROD_W = BIT_LEN_W + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_CLASS,
        S_DIV,
        S_MUL,
        S_TDIFF,
        S_TCMP,
        S_FILL,
        S_SPAN,
        S_DEV,
        S_EMIT,
        S_FINISH
    } t_state;

    // Configuration registers.
    logic [BIT_LEN_W-1:0]   r_bit_len;
    logic [BIT_LEN_W-1:0]   r_bit_tol;
    logic [FRAME_LEN_W-1:0] r_frame_len;
    logic [FRAME_LEN_W-1:0] r_frame_tol;
    logic [FRAME_LEN_W-1:0] r_gap;

    // Frame state.
    t_state              r_state;
    logic                r_frame_open;
    logic [SAMPLE_W-1:0] r_start;
    logic [SAMPLE_W-1:0] r_prev;
    logic                r_prev_lvl;
    logic [CNT_W-1:0]    r_filled;
    logic                r_run_error;
    logic                r_timing_error;

    // Working registers for one edge.
    logic [SAMPLE_W-1:0] r_s;
    logic                r_lvl;
    logic [DIFF_W-1:0]   r_diff;
    logic [RUN_W-1:0]    r_lim;
    t_div_req            r_div_req;
    logic [CNT_W-1:0]    r_n;
    logic                r_mul_start;
    logic [RUN_W-1:0]    r_tdiff;
    logic [CNT_W-1:0]    r_fill_cnt;
    logic [DIFF_W-1:0]   r_span;
    logic [DIFF_W-1:0]   r_dev;

    // Result register.
    logic    r_out_valid;
    t_result r_out;

    // Submodule links.
    logic              div_done;
    logic [Q_W-1:0]    div_quot;
    logic              mul_done;
    logic [PROD_W-1:0] want;
    logic [PROD_W-1:0] tol;
    t_fill_ctl         fill_ctl;
    t_frame_view       view;

    // Combinational helpers.
    logic [BIT_LEN_W-1:0] bit_len_eff;
    logic                 later;
    logic                 can_load;
    logic                 out_load;
    logic [CNT_W-1:0]     rem_bits;
    logic [CNT_W-1:0]     n_n;
    logic [RUN_W:0]       run_minus_want;
    logic [RUN_W:0]       want_minus_run;
    logic [DIFF_W:0]      span_ext;
    logic [DIFF_W:0]      dev_pos;
    logic [DIFF_W:0]      dev_neg;
    t_status              verdict;

    // A zero bit length counts as one sample.
    assign bit_len_eff = (r_bit_len == '0) ? BIT_LEN_W'(1) : r_bit_len;
    // The edge comes strictly after the previous one.
    assign later    = ~r_diff[DIFF_W-1] && (r_diff != '0);
    assign can_load = ~r_out_valid || o_result.ready;
    // A closed frame goes into the result register in this cycle.
    assign out_load = (r_state == S_EMIT) && can_load;

    // Rounded bit count, at least one and no more than the bits still open.
    always_comb begin
        rem_bits = CNT_W'(FRAME_BITS) - r_filled;
        if (div_quot == '0) begin
            n_n = CNT_W'(1);
        end else if (div_quot > {1'b0, rem_bits}) begin
            n_n = rem_bits;
        end else begin
            n_n = div_quot[CNT_W-1:0];
        end
    end

    // Both signs of run minus expected duration, and of span minus frame length.
    always_comb begin
        run_minus_want = {1'b0, r_diff[RUN_W-1:0]} - (RUN_W + 1)'(want);
        want_minus_run = (RUN_W + 1)'(want) - {1'b0, r_diff[RUN_W-1:0]};
        span_ext       = {r_span[DIFF_W-1], r_span};
        dev_pos        = span_ext - (DIFF_W + 1)'(r_frame_len);
        dev_neg        = (DIFF_W + 1)'(r_frame_len) - span_ext;
    end

    // Frame verdict; the first failing check wins.
    always_comb begin
        if (r_run_error) begin
            verdict = ST_BAD_RUN;
        end else if (r_filled < CNT_W'(FRAME_BITS)) begin
            verdict = ST_FEW_BITS;
        end else if (!view.structure_ok) begin
            verdict = ST_BAD_STRUCT;
        end else if (r_dev > DIFF_W'(r_frame_tol)) begin
            verdict = ST_BAD_FRAME;
        end else if (r_timing_error) begin
            verdict = ST_BAD_TIMING;
        end else begin
            verdict = ST_OK;
        end
    end

    // Bits of the previous level go into the frame register one per cycle.
    assign fill_ctl.shift  = (r_state == S_FILL) && (r_fill_cnt != '0);
    assign fill_ctl.bit_in = r_prev_lvl;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_len   <= BIT_LEN_RESET;
            r_bit_tol   <= BIT_TOL_RESET;
            r_frame_len <= FRAME_LEN_RESET;
            r_frame_tol <= FRAME_TOL_RESET;
            r_gap       <= GAP_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                CFG_BIT_LEN:   r_bit_len   <= i_cfg.payload.data[BIT_LEN_W-1:0];
                CFG_BIT_TOL:   r_bit_tol   <= i_cfg.payload.data[BIT_LEN_W-1:0];
                CFG_FRAME_LEN: r_frame_len <= i_cfg.payload.data;
                CFG_FRAME_TOL: r_frame_tol <= i_cfg.payload.data;
                CFG_GAP:       r_gap       <= i_cfg.payload.data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: state, frame state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frame_open    <= 1'b0;
            r_start         <= '0;
            r_prev          <= '0;
            r_prev_lvl      <= 1'b1;
            r_filled        <= '0;
            r_run_error     <= 1'b0;
            r_timing_error  <= 1'b0;
            r_div_req.start <= 1'b0;
            r_mul_start     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            r_mul_start     <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_edge.valid) begin
                        r_s     <= i_edge.payload.sample_number;
                        r_lvl   <= i_edge.payload.level;
                        r_state <= S_DIFF;
                    end
                end

                S_DIFF: begin
                    r_diff  <= {1'b0, r_s} - {1'b0, r_prev};
                    r_lim   <= RUN_W'(r_frame_len) + RUN_W'(r_frame_tol);
                    r_state <= S_CLASS;
                end

                S_CLASS: begin
                    r_div_req.num <= {r_diff[RUN_W-1:0], 1'b0} + NUM_W'(bit_len_eff);
                    r_div_req.den <= {bit_len_eff, 1'b0};
                    if (r_frame_open && later &&
                        (r_diff[SAMPLE_W-1:0] > SAMPLE_W'(r_gap))) begin
                        r_state <= S_SPAN;
                    end else if (r_frame_open) begin
                        if (r_run_error || (r_filled >= CNT_W'(FRAME_BITS))) begin
                            r_state <= S_FINISH;
                        end else if (!later ||
                                     (r_diff[SAMPLE_W-1:0] > SAMPLE_W'(r_lim))) begin
                            r_run_error <= 1'b1;
                            r_state     <= S_FINISH;
                        end else begin
                            r_div_req.start <= 1'b1;
                            r_state         <= S_DIV;
                        end
                    end else begin
                        r_start        <= r_s;
                        r_filled       <= '0;
                        r_run_error    <= 1'b0;
                        r_timing_error <= 1'b0;
                        r_state        <= S_FINISH;
                    end
                end

                S_DIV: begin
                    if (div_done) begin
                        r_n         <= n_n;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL;
                    end
                end

                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_TDIFF;
                    end
                end

                S_TDIFF: begin
                    r_tdiff <= run_minus_want[RUN_W] ? want_minus_run[RUN_W-1:0]
                                                     : run_minus_want[RUN_W-1:0];
                    r_state <= S_TCMP;
                end

                S_TCMP: begin
                    if (r_tdiff > RUN_W'(tol)) begin
                        r_timing_error <= 1'b1;
                    end
                    r_fill_cnt <= r_n;
                    r_state    <= S_FILL;
                end

                S_FILL: begin
                    if (r_fill_cnt != '0) begin
                        r_fill_cnt <= r_fill_cnt - 1'b1;
                        r_filled   <= r_filled + 1'b1;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end

                S_SPAN: begin
                    r_span  <= {1'b0, r_prev} - {1'b0, r_start};
                    r_state <= S_DEV;
                end

                S_DEV: begin
                    r_dev   <= dev_pos[DIFF_W] ? dev_neg[DIFF_W-1:0] : dev_pos[DIFF_W-1:0];
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (can_load) begin
                        r_out.status             <= verdict;
                        r_out.timestamp          <= (verdict == ST_OK) ? view.timestamp : '0;
                        r_out.frame_start_sample <= r_start;
                        r_start                  <= r_s;
                        r_filled                 <= '0;
                        r_run_error              <= 1'b0;
                        r_timing_error           <= 1'b0;
                        r_state                  <= S_FINISH;
                    end
                end

                S_FINISH: begin
                    r_prev       <= r_s;
                    r_prev_lvl   <= r_lvl;
                    r_frame_open <= 1'b1;
                    r_state      <= S_IDLE;
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Rounding divide of the run by the bit length.
    ebtd_divider #(
        .Q_W (Q_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div_req),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // Expected duration and allowed deviation for the bits of this run.
    ebtd_serial_mul #(
        .N_W (CNT_W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_n      (r_n),
        .i_a      (bit_len_eff),
        .i_b      (r_bit_tol),
        .o_done   (mul_done),
        .o_prod_a (want),
        .o_prod_b (tol)
    );

    // Frame bit register with structure check and byte extraction.
    ebtd_frame_shift #(
        .FRAME_BITS (FRAME_BITS)
    ) u_frame (
        .i_clk  (i_clk),
        .i_ctl  (fill_ctl),
        .o_view (view)
    );

    // Channel outputs.
    assign i_edge.ready     = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

endmodule
